// ===== hw/rtl/ryc_pkg.sv =====
// ryc_pkg: shared widths, operation codes, Q-format coefficients and helper
// functions for the RGB/YUV color converter. No dependencies.
package ryc_pkg;

  // Fraction bits of the fixed-point coefficients.
  localparam int CoefFracBits = 12;

  // Payload widths.
  localparam int FuncW   = 2;
  localparam int CompW   = 10;
  localparam int LumaW   = 11;

  // Internal widths.
  localparam int YuvW     = 12;               // forward results and inverse deltas
  localparam int InvResW  = YuvW + 1;         // inverse result before clamping
  localparam int FwdCoefW = CoefFracBits + 1; // forward coefficients are below 1.0
  localparam int FwdW     = CoefFracBits + 12;
  localparam int InvCoefW = CoefFracBits + 3; // inverse coefficients are below 4.0
  localparam int InvW     = CoefFracBits + 15;

  localparam int FracBias = (1 << CoefFracBits) - 1;
  localparam int OfsQ     = 128 << CoefFracBits;
  localparam int Offset   = 128;
  localparam int CompMin  = -512;
  localparam int CompMax  = 511;
  localparam int PixMax   = 255;

  typedef enum logic [FuncW-1:0] {
    FuncToYuv   = 2'd0,
    FuncToRgb   = 2'd1,
    FuncSetLuma = 2'd2
  } func_e;

  localparam logic SpaceRgb = 1'b0;
  localparam logic SpaceYuv = 1'b1;

  // Forward matrix, magnitudes; signs are applied in the sums.
  localparam logic signed [FwdCoefW-1:0] CoefYR =
    FwdCoefW'(((299 << CoefFracBits) + 500) / 1000);
  localparam logic signed [FwdCoefW-1:0] CoefYG =
    FwdCoefW'(((587 << CoefFracBits) + 500) / 1000);
  localparam logic signed [FwdCoefW-1:0] CoefYB =
    FwdCoefW'(((114 << CoefFracBits) + 500) / 1000);
  localparam logic signed [FwdCoefW-1:0] CoefUR =
    FwdCoefW'(((148 << CoefFracBits) + 500) / 1000);
  localparam logic signed [FwdCoefW-1:0] CoefUG =
    FwdCoefW'(((289 << CoefFracBits) + 500) / 1000);
  localparam logic signed [FwdCoefW-1:0] CoefUB =
    FwdCoefW'(((437 << CoefFracBits) + 500) / 1000);
  localparam logic signed [FwdCoefW-1:0] CoefVR =
    FwdCoefW'(((615 << CoefFracBits) + 500) / 1000);
  localparam logic signed [FwdCoefW-1:0] CoefVG =
    FwdCoefW'(((515 << CoefFracBits) + 500) / 1000);
  localparam logic signed [FwdCoefW-1:0] CoefVB =
    FwdCoefW'(((100 << CoefFracBits) + 500) / 1000);

  // Inverse matrix, magnitudes.
  localparam logic signed [InvCoefW-1:0] CoefRV =
    InvCoefW'(((1140 << CoefFracBits) + 500) / 1000);
  localparam logic signed [InvCoefW-1:0] CoefGU =
    InvCoefW'(((394 << CoefFracBits) + 500) / 1000);
  localparam logic signed [InvCoefW-1:0] CoefGV =
    InvCoefW'(((581 << CoefFracBits) + 500) / 1000);
  localparam logic signed [InvCoefW-1:0] CoefBU =
    InvCoefW'(((2028 << CoefFracBits) + 500) / 1000);
  localparam logic signed [InvCoefW-1:0] CoefBV =
    InvCoefW'(((2 << CoefFracBits) + 500) / 1000);

  // Divide by 2^CoefFracBits, rounding toward zero.
  function automatic logic signed [YuvW-1:0] trunc_fwd(input logic signed [FwdW-1:0] s);
    logic signed [FwdW-1:0] t;
    t = s + (s[FwdW-1] ? FwdW'(FracBias) : FwdW'(0));
    t = t >>> CoefFracBits;
    return t[YuvW-1:0];
  endfunction

  function automatic logic signed [InvResW-1:0] trunc_inv(input logic signed [InvW-1:0] s);
    logic signed [InvW-1:0] t;
    t = s + (s[InvW-1] ? InvW'(FracBias) : InvW'(0));
    t = t >>> CoefFracBits;
    return t[InvResW-1:0];
  endfunction

  // Saturate to the signed channel range.
  function automatic logic signed [CompW-1:0] clamp_comp(input logic signed [YuvW-1:0] v);
    logic signed [CompW-1:0] r;
    if (v > YuvW'(CompMax)) begin
      r = CompW'(CompMax);
    end else if (v < YuvW'(CompMin)) begin
      r = CompW'(CompMin);
    end else begin
      r = v[CompW-1:0];
    end
    return r;
  endfunction

  // Clamp to 0..255.
  function automatic logic signed [CompW-1:0] clamp_pix(input logic signed [InvResW-1:0] v);
    logic signed [CompW-1:0] r;
    if (v < InvResW'(0)) begin
      r = '0;
    end else if (v > InvResW'(PixMax)) begin
      r = CompW'(PixMax);
    end else begin
      r = v[CompW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [CompW-1:0] clamp_luma(input logic signed [LumaW-1:0] v);
    logic signed [CompW-1:0] r;
    if (v < LumaW'(0)) begin
      r = '0;
    end else if (v > LumaW'(PixMax)) begin
      r = CompW'(PixMax);
    end else begin
      r = v[CompW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/ryc_pix_if.sv =====
// ryc_pix_in_if / ryc_pix_out_if: valid/ready pixel channels of the color
// converter. Depends on ryc_pkg for field widths.
interface ryc_pix_in_if;
  logic                               valid;
  logic                               ready;
  logic [ryc_pkg::FuncW-1:0]          func;
  logic                               space;
  logic signed [ryc_pkg::CompW-1:0]   comp_a;
  logic signed [ryc_pkg::CompW-1:0]   comp_b;
  logic signed [ryc_pkg::CompW-1:0]   comp_c;
  logic signed [ryc_pkg::LumaW-1:0]   new_luma;

  modport source (output valid, func, space, comp_a, comp_b, comp_c, new_luma,
                  input ready);
  modport sink   (input valid, func, space, comp_a, comp_b, comp_c, new_luma,
                  output ready);
endinterface

interface ryc_pix_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ryc_pkg::CompW-1:0]   out_a;
  logic signed [ryc_pkg::CompW-1:0]   out_b;
  logic signed [ryc_pkg::CompW-1:0]   out_c;
  logic                               out_space;

  modport source (output valid, out_a, out_b, out_c, out_space, input ready);
  modport sink   (input valid, out_a, out_b, out_c, out_space, output ready);
endinterface

// ===== hw/rtl/rgb_yuv_color_converter_core.sv =====
// rgb_yuv_color_converter_core: four-stage pipelined RGB<->YUV pixel converter.
// Depends on ryc_pkg and the channel interfaces in ryc_pix_if.sv.
// An accepted input beat passes through stage 1, stage 2, stage 3 and the output register to its output beat.
// Throughput: one pixel per clock; the whole pipe advances together and
// freezes while the output beat is held by the sink.
// Reset clears the stage valid bits only; the payload registers are not reset.
module rgb_yuv_color_converter_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ryc_pix_in_if.sink           pix_i,
  ryc_pix_out_if.source        pix_o
);

  localparam int FwdW    = ryc_pkg::FwdW;
  localparam int InvW    = ryc_pkg::InvW;
  localparam int YuvW    = ryc_pkg::YuvW;
  localparam int CompW   = ryc_pkg::CompW;

  // Pipe advances when the output register is empty or being drained.
  logic advance;
  logic out_valid_q;
  assign advance     = !out_valid_q || pix_o.ready;
  assign pix_i.ready = advance;

  // --------------------------------------------------------------------------
  // Stage 1: register the input beat and the nine forward products.
  // --------------------------------------------------------------------------
  logic                     s1_valid_q;
  logic [1:0]               s1_func_q;
  logic                     s1_space_q;
  logic signed [CompW-1:0]  s1_a_q, s1_b_q, s1_c_q, s1_luma_q;
  logic signed [FwdW-1:0]   s1_yr_q, s1_yg_q, s1_yb_q;
  logic signed [FwdW-1:0]   s1_ur_q, s1_ug_q, s1_ub_q;
  logic signed [FwdW-1:0]   s1_vr_q, s1_vg_q, s1_vb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_func_q  <= pix_i.func;
      s1_space_q <= pix_i.space;
      s1_a_q     <= pix_i.comp_a;
      s1_b_q     <= pix_i.comp_b;
      s1_c_q     <= pix_i.comp_c;
      s1_luma_q  <= ryc_pkg::clamp_luma(pix_i.new_luma);
      s1_yr_q    <= FwdW'(pix_i.comp_a) * FwdW'(ryc_pkg::CoefYR);
      s1_yg_q    <= FwdW'(pix_i.comp_b) * FwdW'(ryc_pkg::CoefYG);
      s1_yb_q    <= FwdW'(pix_i.comp_c) * FwdW'(ryc_pkg::CoefYB);
      s1_ur_q    <= FwdW'(pix_i.comp_a) * FwdW'(ryc_pkg::CoefUR);
      s1_ug_q    <= FwdW'(pix_i.comp_b) * FwdW'(ryc_pkg::CoefUG);
      s1_ub_q    <= FwdW'(pix_i.comp_c) * FwdW'(ryc_pkg::CoefUB);
      s1_vr_q    <= FwdW'(pix_i.comp_a) * FwdW'(ryc_pkg::CoefVR);
      s1_vg_q    <= FwdW'(pix_i.comp_b) * FwdW'(ryc_pkg::CoefVG);
      s1_vb_q    <= FwdW'(pix_i.comp_c) * FwdW'(ryc_pkg::CoefVB);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: forward sums with the 128 chroma offset, truncated toward zero.
  // Kept at full width: set_luminance feeds unsaturated U/V to the inverse.
  // --------------------------------------------------------------------------
  logic signed [FwdW-1:0]   fwd_y_sum, fwd_u_sum, fwd_v_sum;
  logic                     s2_valid_q;
  logic [1:0]               s2_func_q;
  logic                     s2_space_q;
  logic signed [CompW-1:0]  s2_a_q, s2_b_q, s2_c_q, s2_luma_q;
  logic signed [YuvW-1:0]   s2_y_q, s2_u_q, s2_v_q;

  assign fwd_y_sum = s1_yr_q + s1_yg_q + s1_yb_q;
  assign fwd_u_sum = s1_ub_q - s1_ur_q - s1_ug_q + FwdW'(ryc_pkg::OfsQ);
  assign fwd_v_sum = s1_vr_q - s1_vg_q - s1_vb_q + FwdW'(ryc_pkg::OfsQ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_func_q  <= s1_func_q;
      s2_space_q <= s1_space_q;
      s2_a_q     <= s1_a_q;
      s2_b_q     <= s1_b_q;
      s2_c_q     <= s1_c_q;
      s2_luma_q  <= s1_luma_q;
      s2_y_q     <= ryc_pkg::trunc_fwd(fwd_y_sum);
      s2_u_q     <= ryc_pkg::trunc_fwd(fwd_u_sum);
      s2_v_q     <= ryc_pkg::trunc_fwd(fwd_v_sum);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: decode the operation, build the pass-through result, pick the
  // inverse operands and register the inverse products.
  // --------------------------------------------------------------------------
  logic signed [CompW-1:0]  pass_a, pass_b, pass_c;
  logic                     pass_space;
  logic                     use_inv;
  logic signed [YuvW-1:0]   inv_y, inv_u, inv_v;
  logic signed [YuvW-1:0]   inv_du, inv_dv;

  always_comb begin
    pass_a     = s2_a_q;
    pass_b     = s2_b_q;
    pass_c     = s2_c_q;
    pass_space = s2_space_q;
    use_inv    = 1'b0;
    case (s2_func_q)
      ryc_pkg::FuncToYuv: begin
        if (s2_space_q == ryc_pkg::SpaceRgb) begin
          pass_a = ryc_pkg::clamp_comp(s2_y_q);
          pass_b = ryc_pkg::clamp_comp(s2_u_q);
          pass_c = ryc_pkg::clamp_comp(s2_v_q);
        end
        pass_space = ryc_pkg::SpaceYuv;
      end
      ryc_pkg::FuncToRgb: begin
        use_inv    = (s2_space_q == ryc_pkg::SpaceYuv);
        pass_space = ryc_pkg::SpaceRgb;
      end
      ryc_pkg::FuncSetLuma: begin
        // RGB: round trip through YUV with the new luma; YUV: swap Y only.
        use_inv = (s2_space_q == ryc_pkg::SpaceRgb);
        pass_a  = s2_luma_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (s2_func_q == ryc_pkg::FuncToRgb) begin
      inv_y = YuvW'(s2_a_q);
      inv_u = YuvW'(s2_b_q);
      inv_v = YuvW'(s2_c_q);
    end else begin
      inv_y = YuvW'(s2_luma_q);
      inv_u = s2_u_q;
      inv_v = s2_v_q;
    end
  end

  assign inv_du = inv_u - YuvW'(ryc_pkg::Offset);
  assign inv_dv = inv_v - YuvW'(ryc_pkg::Offset);

  logic                     s3_valid_q;
  logic                     s3_use_inv_q;
  logic                     s3_space_q;
  logic signed [CompW-1:0]  s3_a_q, s3_b_q, s3_c_q;
  logic signed [InvW-1:0]   s3_yq_q, s3_rv_q, s3_gu_q, s3_gv_q, s3_bu_q, s3_bv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (advance) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s3_use_inv_q <= use_inv;
      s3_space_q   <= pass_space;
      s3_a_q       <= pass_a;
      s3_b_q       <= pass_b;
      s3_c_q       <= pass_c;
      s3_yq_q      <= InvW'(inv_y) <<< ryc_pkg::CoefFracBits;
      s3_rv_q      <= InvW'(inv_dv) * InvW'(ryc_pkg::CoefRV);
      s3_gu_q      <= InvW'(inv_du) * InvW'(ryc_pkg::CoefGU);
      s3_gv_q      <= InvW'(inv_dv) * InvW'(ryc_pkg::CoefGV);
      s3_bu_q      <= InvW'(inv_du) * InvW'(ryc_pkg::CoefBU);
      s3_bv_q      <= InvW'(inv_dv) * InvW'(ryc_pkg::CoefBV);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: inverse sums, truncate, clamp to 0..255, select, output register.
  // --------------------------------------------------------------------------
  logic signed [InvW-1:0]   inv_r_sum, inv_g_sum, inv_b_sum;
  logic signed [CompW-1:0]  out_a_d, out_b_d, out_c_d;
  logic signed [CompW-1:0]  out_a_q, out_b_q, out_c_q;
  logic                     out_space_q;
  logic                     out_inv_q;

  assign inv_r_sum = s3_yq_q + s3_rv_q;
  assign inv_g_sum = s3_yq_q - s3_gu_q - s3_gv_q;
  assign inv_b_sum = s3_yq_q + s3_bu_q + s3_bv_q;

  always_comb begin
    if (s3_use_inv_q) begin
      out_a_d = ryc_pkg::clamp_pix(ryc_pkg::trunc_inv(inv_r_sum));
      out_b_d = ryc_pkg::clamp_pix(ryc_pkg::trunc_inv(inv_g_sum));
      out_c_d = ryc_pkg::clamp_pix(ryc_pkg::trunc_inv(inv_b_sum));
    end else begin
      out_a_d = s3_a_q;
      out_b_d = s3_b_q;
      out_c_d = s3_c_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_a_q     <= out_a_d;
      out_b_q     <= out_b_d;
      out_c_q     <= out_c_d;
      out_space_q <= s3_space_q;
      out_inv_q   <= s3_use_inv_q;
    end
  end

  assign pix_o.valid     = out_valid_q;
  assign pix_o.out_a     = out_a_q;
  assign pix_o.out_b     = out_b_q;
  assign pix_o.out_c     = out_c_q;
  assign pix_o.out_space = out_space_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A stage-1 beat is either freshly accepted or held by a stall.
  a_s1_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $past(pix_i.valid && pix_i.ready) || $past(s1_valid_q && !advance))
    else $error("stage 1 valid without an accepted beat");

  // Input is only back-pressured by a held output beat.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> out_valid_q && !pix_o.ready)
    else $error("input stalled without output back-pressure");

  // Inverse results are clamped RGB.
  a_inv_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_inv_q |->
      out_a_q >= 0 && out_a_q <= 255 && out_b_q >= 0 && out_b_q <= 255 &&
      out_c_q >= 0 && out_c_q <= 255)
    else $error("inverse result outside 0..255");

  a_inv_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_inv_q |-> out_space_q == ryc_pkg::SpaceRgb)
    else $error("inverse result not tagged RGB");

endmodule
